// ----- design/ffba_pkg.sv -----
// Package for the first-fit block allocator.
// Holds the default sizes, the controller state type, the result record and
// the saturating add used by the scan controller. No dependencies.
package ffba_pkg;

  localparam int DEF_NUM_ENTRIES = 16;
  localparam int DEF_SIZE_BITS   = 16;

  localparam int TOTAL_W   = 32;
  localparam int INDEX_W   = 4;
  localparam int AMOUNT_W  = 16;
  localparam int COUNT_W   = 5;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE,
    ST_FINISH
  } ctrl_state_t;

  typedef struct packed {
    logic                 fitted;
    logic [INDEX_W-1:0]   chosen_index;
    logic [TOTAL_W-1:0]   inner_waste_total;
    logic [TOTAL_W-1:0]   outer_waste_total;
  } result_t;

  function automatic logic [TOTAL_W-1:0] sat_add(input logic [TOTAL_W-1:0] a,
                                                 input logic [TOTAL_W-1:0] b);
    logic [TOTAL_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TOTAL_W] ? {TOTAL_W{1'b1}} : s[TOTAL_W-1:0];
  endfunction

endpackage

// ----- design/ffba_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
// Used for the capacity table of the first-fit allocator. No dependencies.
module ffba_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- design/ffba_ctrl.sv -----
// Scan controller of the first-fit allocator: loads entries, scans the
// capacity table through the RAM read port, updates the winner and the totals.
// Depends on ffba_pkg.
module ffba_ctrl
  import ffba_pkg::*;
#(
  parameter int NUM_ENTRIES = DEF_NUM_ENTRIES,
  parameter int SIZE_BITS   = DEF_SIZE_BITS,
  localparam int IDX_W = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1,
  localparam int CNT_W = $clog2(NUM_ENTRIES + 1)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 mode,
  input  logic [INDEX_W-1:0]   entry_index,
  input  logic [AMOUNT_W-1:0]  amount,
  input  logic [CNT_W-1:0]     limit,
  output logic                 res_valid,
  input  logic                 res_ready,
  output result_t              res,
  output logic                 ram_we,
  output logic [IDX_W-1:0]     ram_waddr,
  output logic [SIZE_BITS-1:0] ram_wdata,
  output logic [IDX_W-1:0]     ram_raddr,
  input  logic [SIZE_BITS-1:0] ram_rdata
);

  ctrl_state_t state, state_next;

  logic [CNT_W-1:0]     ptr;
  logic                 chk_valid;
  logic [IDX_W-1:0]     chk_idx;
  logic [SIZE_BITS-1:0] amt;
  logic [SIZE_BITS-1:0] left;
  logic                 fit;
  logic [IDX_W-1:0]     chosen;
  logic [TOTAL_W-1:0]   inner_sum;
  logic [TOTAL_W-1:0]   outer_sum;

  logic accept;
  logic hit;
  logic last_miss;
  logic issue;
  logic load_ok;

  assign accept    = in_valid && in_ready;
  assign hit       = chk_valid && (ram_rdata >= amt);
  assign last_miss = chk_valid && !hit && ((CNT_W'(chk_idx) + CNT_W'(1)) == limit);
  assign issue     = ptr < limit;
  assign load_ok   = int'(entry_index) < NUM_ENTRIES;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (mode && (limit != '0)) begin
            state_next = ST_SCAN;
          end else begin
            state_next = ST_FINISH;
          end
        end
      end
      ST_SCAN: begin
        priority if (hit) begin
          state_next = ST_UPDATE;
        end else if (last_miss) begin
          state_next = ST_FINISH;
        end
      end
      ST_UPDATE: state_next = ST_FINISH;
      ST_FINISH: begin
        if (res_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready  = 1'b0;
    res_valid = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = chosen;
    ram_wdata = left;
    ram_raddr = ptr[IDX_W-1:0];
    unique case (state)
      ST_IDLE: begin
        in_ready  = 1'b1;
        ram_we    = in_valid && !mode && load_ok;
        ram_waddr = IDX_W'(entry_index);
        ram_wdata = SIZE_BITS'(amount);
      end
      ST_SCAN: ;
      ST_UPDATE: ram_we = 1'b1;
      ST_FINISH: res_valid = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      ptr       <= '0;
      chk_valid <= 1'b0;
      inner_sum <= '0;
      outer_sum <= '0;
    end else begin
      state <= state_next;
      unique case (state)
        ST_IDLE: begin
          ptr       <= '0;
          chk_valid <= 1'b0;
          if (accept && mode && (limit == '0)) begin
            outer_sum <= sat_add(outer_sum, TOTAL_W'(SIZE_BITS'(amount)));
          end
        end
        ST_SCAN: begin
          chk_valid <= issue && !hit;
          if (issue) begin
            ptr <= ptr + CNT_W'(1);
          end
          if (last_miss) begin
            outer_sum <= sat_add(outer_sum, TOTAL_W'(amt));
          end
        end
        ST_UPDATE: inner_sum <= sat_add(inner_sum, TOTAL_W'(left));
        ST_FINISH: ;
        default: ;
      endcase
    end
  end

  // item payload and scan results
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && accept) begin
      amt    <= SIZE_BITS'(amount);
      fit    <= 1'b0;
      chosen <= '0;
    end
    if (state == ST_SCAN) begin
      chk_idx <= ptr[IDX_W-1:0];
      if (hit) begin
        left   <= ram_rdata - amt;
        chosen <= chk_idx;
        fit    <= 1'b1;
      end
    end
  end

  assign res = {fit, INDEX_W'(chosen), inner_sum, outer_sum};

endmodule

// ----- design/first_fit_block_allocator.sv -----
// First-fit block allocator: a table of remaining block capacities in a
// single-port-read synchronous RAM. A load item writes one entry and goes
// straight to its result. An allocate item walks entries 0 to block_count-1
// (capped at NUM_ENTRIES) through the RAM read port, one entry a cycle, and
// stops at the first entry that fits; with block_count zero it goes straight
// to its result, as a load does. The controller is back in idle at the edge
// that fills the output register, so the next item is taken at the earliest
// edge where the result can be taken. The result sits in an output register,
// so the next item is taken while a result waits to be taken. Both totals
// saturate.
// Depends on ffba_pkg, ffba_ram and ffba_ctrl.
module first_fit_block_allocator
  import ffba_pkg::*;
#(
  parameter int NUM_ENTRIES = DEF_NUM_ENTRIES,
  parameter int SIZE_BITS   = DEF_SIZE_BITS
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [COUNT_W-1:0]  cfg_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                mode,
  input  logic [INDEX_W-1:0]  entry_index,
  input  logic [AMOUNT_W-1:0] amount,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                fitted,
  output logic [INDEX_W-1:0]  chosen_index,
  output logic [TOTAL_W-1:0]  inner_waste_total,
  output logic [TOTAL_W-1:0]  outer_waste_total
);

  localparam int IDX_W = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
  localparam int CNT_W = $clog2(NUM_ENTRIES + 1);

  logic [COUNT_W-1:0]   block_count;
  logic [CNT_W-1:0]     limit;
  logic                 res_valid;
  logic                 res_ready;
  result_t              res;
  result_t              out_reg;
  logic                 ram_we;
  logic [IDX_W-1:0]     ram_waddr;
  logic [SIZE_BITS-1:0] ram_wdata;
  logic [IDX_W-1:0]     ram_raddr;
  logic [SIZE_BITS-1:0] ram_rdata;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      block_count <= '0;
    end else if (cfg_valid && cfg_ready) begin
      block_count <= cfg_data;
    end
  end

  // clamp the search length to the table size
  assign limit = (int'(block_count) > NUM_ENTRIES) ? CNT_W'(NUM_ENTRIES)
                                                   : CNT_W'(block_count);

  ffba_ctrl #(
    .NUM_ENTRIES(NUM_ENTRIES),
    .SIZE_BITS  (SIZE_BITS)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .mode       (mode),
    .entry_index(entry_index),
    .amount     (amount),
    .limit      (limit),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata),
    .ram_raddr  (ram_raddr),
    .ram_rdata  (ram_rdata)
  );

  ffba_ram #(
    .WIDTH(SIZE_BITS),
    .DEPTH(NUM_ENTRIES)
  ) u_cap_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // output register: take a new result once the old one is transferred
  assign res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_reg <= res;
    end
  end

  assign fitted            = out_reg.fitted;
  assign chosen_index      = out_reg.chosen_index;
  assign inner_waste_total = out_reg.inner_waste_total;
  assign outer_waste_total = out_reg.outer_waste_total;

endmodule

// ----- tb/sv/ffba_tb_pkg.sv -----
// Scoreboard for the first-fit block allocator bench: mirrors the capacity table
// and the two waste totals, queues the outcome due for each transfer, and checks results.
// Depends on ffba_pkg for widths and the result record.
`timescale 1ns / 1ps
package ffba_tb_pkg;
  import ffba_pkg::*;

  localparam int TABLE_DEPTH = 16;
  localparam int MAX_REPORTS = 20;
  localparam bit MODE_LOAD   = 1'b0;
  localparam bit MODE_ALLOC  = 1'b1;
  localparam logic [TOTAL_W-1:0] TOTAL_CEIL = '1;

  class alloc_scoreboard;
    logic [AMOUNT_W-1:0] capacity [TABLE_DEPTH];
    logic [COUNT_W-1:0]  block_count;
    logic [TOTAL_W-1:0]  inner_sum;
    logic [TOTAL_W-1:0]  outer_sum;
    result_t             outcomes [$];
    int                  errors;
    int                  results_seen;
    int                  loads;
    int                  placed;
    int                  unplaced;

    function new();
      foreach (capacity[i]) capacity[i] = '0;
      block_count  = '0;
      inner_sum    = '0;
      outer_sum    = '0;
      errors       = 0;
      results_seen = 0;
      loads        = 0;
      placed       = 0;
      unplaced     = 0;
    endfunction

    // Entries an allocate walks; counts past the table stop at its end.
    function int searched();
      return (block_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(block_count);
    endfunction

    function logic [TOTAL_W-1:0] add_capped(logic [TOTAL_W-1:0] total,
                                            logic [AMOUNT_W-1:0] inc);
      if (TOTAL_CEIL - total < inc) return TOTAL_CEIL;
      return total + inc;
    endfunction

    function void note_item(bit m, logic [INDEX_W-1:0] idx, logic [AMOUNT_W-1:0] amt);
      result_t r;
      int      j;
      r = '0;
      if (m == MODE_LOAD) begin
        capacity[idx] = amt;
        loads++;
      end else begin
        for (j = 0; j < searched() && !r.fitted; j++) begin
          if (capacity[j] >= amt) begin
            capacity[j]    = capacity[j] - amt;
            inner_sum      = add_capped(inner_sum, capacity[j]);
            r.fitted       = 1'b1;
            r.chosen_index = INDEX_W'(j);
          end
        end
        if (r.fitted) begin
          placed++;
        end else begin
          outer_sum = add_capped(outer_sum, amt);
          unplaced++;
        end
      end
      r.inner_waste_total = inner_sum;
      r.outer_waste_total = outer_sum;
      outcomes.push_back(r);
    endfunction

    function void compare(string field, logic [TOTAL_W-1:0] want, logic [TOTAL_W-1:0] got);
      if (got !== want) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: %s mismatch on result %0d: expected %0d, got %0d",
                   $time, field, results_seen, want, got);
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (outcomes.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: stray result: expected none, got fitted=%0d index=%0d %0d %0d",
                   $time, got.fitted, got.chosen_index, got.inner_waste_total,
                   got.outer_waste_total);
      end else begin
        want = outcomes.pop_front();
        results_seen++;
        compare("fitted", TOTAL_W'(want.fitted), TOTAL_W'(got.fitted));
        compare("chosen_index", TOTAL_W'(want.chosen_index), TOTAL_W'(got.chosen_index));
        compare("inner_waste_total", want.inner_waste_total, got.inner_waste_total);
        compare("outer_waste_total", want.outer_waste_total, got.outer_waste_total);
      end
    endfunction
  endclass

endpackage

// ----- tb/sv/tb_first_fit_block_allocator.sv -----
// Top-level bench for first_fit_block_allocator: directed loads and requests, then
// random phases over several block counts with idle gaps and a long receiver hold-off.
// Depends on ffba_pkg, ffba_tb_pkg and the allocator RTL.
`timescale 1ns / 1ps
module tb_first_fit_block_allocator;
  import ffba_pkg::*;
  import ffba_tb_pkg::*;

  localparam int DRAIN_CYCLES    = 30;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int PHASE_ITEMS     = 125;
  localparam int PHASE_COUNT     = 8;

  logic                clk         = 1'b0;
  logic                rst         = 1'b1;
  logic                cfg_valid   = 1'b0;
  logic [COUNT_W-1:0]  cfg_data    = '0;
  logic                in_valid    = 1'b0;
  logic                mode        = 1'b0;
  logic [INDEX_W-1:0]  entry_index = '0;
  logic [AMOUNT_W-1:0] amount      = '0;
  logic                out_ready   = 1'b0;
  logic                cfg_ready;
  logic                in_ready;
  logic                out_valid;
  logic                fitted;
  logic [INDEX_W-1:0]  chosen_index;
  logic [TOTAL_W-1:0]  inner_waste_total;
  logic [TOTAL_W-1:0]  outer_waste_total;

  bit idle_on       = 1'b1;
  bit hold_off_req  = 1'b0;
  int settings_used = 0;

  logic [AMOUNT_W-1:0] seed_caps [TABLE_DEPTH] = '{
    16'h0000, 16'hFFFF, 16'h0001, 16'h5555, 16'hAAAA, 16'h00FF, 16'hFF00, 16'h0002,
    16'h8000, 16'h7FFF, 16'h0003, 16'h0F0F, 16'hF0F0, 16'h0064, 16'h1234, 16'hFFFF};
  logic [COUNT_W-1:0] phase_counts [PHASE_COUNT] = '{1, 16, 0, 31, 7, 17, 3, 12};

  alloc_scoreboard alloc_sb = new();

  first_fit_block_allocator u_top (
    .clk               (clk),
    .rst               (rst),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .mode              (mode),
    .entry_index       (entry_index),
    .amount            (amount),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .fitted            (fitted),
    .chosen_index      (chosen_index),
    .inner_waste_total (inner_waste_total),
    .outer_waste_total (outer_waste_total)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) alloc_sb.note_item(mode, entry_index, amount);
      if (out_valid && out_ready)
        alloc_sb.check_result({fitted, chosen_index, inner_waste_total, outer_waste_total});
    end
  end

  function automatic int pick_gap();
    if (!idle_on) return 0;
    case ($urandom_range(0, 19))
      0:             return $urandom_range(10, 40);
      1, 2, 3, 4, 5: return $urandom_range(1, 3);
      default:       return 0;
    endcase
  endfunction

  function automatic logic [AMOUNT_W-1:0] rand_amount();
    logic [AMOUNT_W-1:0] v;
    case ($urandom_range(0, 4))
      0:       v = AMOUNT_W'($urandom_range(0, 15));
      1:       v = AMOUNT_W'($urandom_range(0, 255));
      2:       v = '1;
      default: v = AMOUNT_W'($urandom());
    endcase
    return v;
  endfunction

  // Leave valid high after a transfer; drop it only when a gap follows.
  task automatic send_item(bit m, logic [INDEX_W-1:0] idx, logic [AMOUNT_W-1:0] amt);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    mode        <= m;
    entry_index <= idx;
    amount      <= amt;
    in_valid    <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (alloc_sb.outcomes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_block_count(logic [COUNT_W-1:0] count);
    cfg_data  <= count;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    alloc_sb.block_count = count;
    settings_used++;
  endtask

  task automatic run_phase(logic [COUNT_W-1:0] count, bit with_idle, bit with_hold);
    logic [AMOUNT_W-1:0] size;
    int                  reach;
    int                  cap;
    write_block_count(count);
    idle_on      = with_idle;
    hold_off_req = with_hold;
    repeat (PHASE_ITEMS) begin
      reach = alloc_sb.searched();
      if ($urandom_range(0, 99) < 35) begin
        send_item(MODE_LOAD, INDEX_W'($urandom_range(0, 15)), rand_amount());
      end else begin
        if (reach == 0 || $urandom_range(0, 3) == 0) begin
          size = rand_amount();
        end else begin
          // Aim at a live entry so requests land near the fit boundary.
          cap = int'(alloc_sb.capacity[$urandom_range(0, reach - 1)]);
          case ($urandom_range(0, 3))
            0:       size = AMOUNT_W'(cap);
            1:       size = (cap == 65535) ? AMOUNT_W'(cap) : AMOUNT_W'(cap + 1);
            2:       size = AMOUNT_W'(cap - int'($urandom_range(0, (cap > 16) ? 16 : cap)));
            default: size = AMOUNT_W'($urandom_range(0, cap));
          endcase
        end
        send_item(MODE_ALLOC, INDEX_W'($urandom_range(0, 15)), size);
      end
    end
    drain();
  endtask

  initial begin : result_sink
    int span;
    while (rst) @(posedge clk);
    forever begin
      if (hold_off_req) begin
        // Hold off long enough for the block to back up into its input.
        out_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_off_req = 1'b0;
      end else begin
        span = 1;
        if (!idle_on) begin
          out_ready <= 1'b1;
        end else begin
          case ($urandom_range(0, 9))
            0: begin
              out_ready <= 1'b0;
              span = $urandom_range(10, 40);
            end
            1, 2: begin
              out_ready <= 1'b0;
              span = $urandom_range(1, 3);
            end
            default: begin
              out_ready <= 1'b1;
              span = $urandom_range(1, 8);
            end
          endcase
        end
        repeat (span) @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    int k;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Load every entry before any request so no scan touches an unwritten entry.
    write_block_count(16);
    for (k = 0; k < TABLE_DEPTH; k++) send_item(MODE_LOAD, INDEX_W'(k), seed_caps[k]);
    send_item(MODE_ALLOC, 4'd9, 16'h0000);
    send_item(MODE_ALLOC, 4'd0, 16'hFFFF);
    send_item(MODE_ALLOC, 4'd15, 16'hFFFF);
    send_item(MODE_ALLOC, 4'd0, 16'hFFFF);
    send_item(MODE_ALLOC, 4'd0, 16'h0001);
    send_item(MODE_LOAD, 4'd0, 16'hFFFF);
    // Zero request against a full entry wastes the whole block.
    send_item(MODE_ALLOC, 4'd0, 16'h0000);
    drain();
    write_block_count(0);
    send_item(MODE_ALLOC, 4'd0, 16'h0005);
    drain();
    write_block_count(31);
    send_item(MODE_ALLOC, 4'd0, 16'h00C8);
    drain();

    for (k = 0; k < PHASE_COUNT; k++) run_phase(phase_counts[k], k != 3, k == 1 || k == 5);

    run_phase(16, 1'b1, 1'b0);

    $display("Checked %0d results: %0d loads, %0d placed, %0d unplaced over %0d counts.",
             alloc_sb.results_seen, alloc_sb.loads, alloc_sb.placed, alloc_sb.unplaced,
             settings_used);
    $display("Waste totals finished at %0d internal and %0d external.",
             alloc_sb.inner_sum, alloc_sb.outer_sum);
    if (alloc_sb.errors == 0 && alloc_sb.outcomes.size() == 0) begin
      $display("first_fit_block_allocator verification clean");
    end else begin
      $display("first_fit_block_allocator verification failed");
    end
    $finish;
  end

  initial begin : watchdog
    #10_000_000;
    $display("Timed out with %0d results outstanding.", alloc_sb.outcomes.size());
    $display("first_fit_block_allocator verification failed");
    $finish;
  end

endmodule
